// ===== sv/cswrl_pkg.sv =====
// Shared widths, command and verdict codes and register indexes of the
// client sliding-window rate limiter.
// No dependencies; imported by the RAM, the core and the checker.
`default_nettype none

package cswrl_pkg;

  // Default sizing of the client table and of the bucket ring.
  localparam int CLIENTS_DEF = 256;
  localparam int BUCKETS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 8;
  localparam int TICK_W     = 32;
  localparam int VERDICT_W  = 2;
  localparam int CNT_W      = 16;
  localparam int STAMP_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Event commands.
  localparam logic [CMD_W-1:0] CMD_OPEN    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;

  // Verdicts.
  localparam logic [VERDICT_W-1:0] V_PASS    = 2'd0;
  localparam logic [VERDICT_W-1:0] V_BLOCK   = 2'd1;
  localparam logic [VERDICT_W-1:0] V_NO_CONN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REQ_RATE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_BURST = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_RATE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_MAX  = 4'd3;

endpackage

`default_nettype wire

// ===== sv/cswrl_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on cswrl_pkg for its default width and depth.
`default_nettype none

module cswrl_ram
  import cswrl_pkg::*;
#(
  parameter int WIDTH = CNT_W,
  parameter int DEPTH = CLIENTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port; the read data register holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/client_sliding_window_rate_limiter_core.sv =====
// Channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------
// event    | in        | in_valid / in_stall | command, client_slot, now_tick
// result   | out       | out_valid/out_stall | verdict
// config   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An event passes from its transfer to its result through the client row
// read, the bucket index, the row update and write-back, and two adder levels
// of the window sum. The next event is taken once the result is registered,
// so the block does not take a new event while one is in progress.
// After reset a clearing pass writes zero to every client row before the first
// event is taken; configuration writes are taken at all times. A stalled
// result holds the sequencer in its last step.
// Depends on cswrl_pkg and cswrl_ram.
`default_nettype none

module client_sliding_window_rate_limiter_core
  import cswrl_pkg::*;
#(
  parameter int CLIENTS = CLIENTS_DEF,
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Event channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [SLOT_W-1:0]     client_slot,
  input  wire logic [TICK_W-1:0]     now_tick,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VERDICT_W-1:0]       verdict,
  // Configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W  = $clog2(CLIENTS);
  localparam int BIDX_W  = $clog2(BUCKETS);
  localparam int BKT_W   = STAMP_W + 2 * CNT_W;
  localparam int ROW_W   = BUCKETS * BKT_W + CNT_W;
  localparam int GROUPS  = (BUCKETS + 3) / 4;
  localparam int PART_W  = CNT_W + 2;
  localparam int SUM_W   = CNT_W + BIDX_W + 1;
  // Reciprocal of the ring length; the quotient it gives is low by at most one.
  localparam logic [TICK_W-1:0] RECIP = TICK_W'((64'd1 << TICK_W) / BUCKETS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_SUM1  = 3'd4;
  localparam logic [2:0] S_SUM2  = 3'd5;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [ADDR_W-1:0]      clr_addr;

  logic [CNT_W-1:0]       lim_rq_window;
  logic [CNT_W-1:0]       lim_rq_bucket;
  logic [CNT_W-1:0]       lim_cn_window;
  logic [CNT_W-1:0]       lim_cn_open;

  logic [CMD_W-1:0]       cmd_q;
  logic [TICK_W-1:0]      tick_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   live_q;
  logic [TICK_W-1:0]      quot_q;
  logic [BIDX_W-1:0]      bidx_q;

  logic [VERDICT_W-1:0]   verdict_q;
  logic                   need_sum_q;
  logic [CNT_W-1:0]       limit_q;
  logic [CNT_W-1:0]       sel_q  [BUCKETS];
  logic [PART_W-1:0]      part_q [GROUPS];

  logic                   in_acc;
  logic                   slot_ok;
  logic [31:0]            slot_wide;
  logic [2*TICK_W-1:0]    prod;
  logic [TICK_W-1:0]      rem;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       row_new;

  logic [VERDICT_W-1:0]   verdict_new;
  logic                   need_sum_new;
  logic [CNT_W-1:0]       limit_new;
  logic [CNT_W-1:0]       sel_new [BUCKETS];

  logic [SUM_W-1:0]       total;
  logic                   out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == S_SUM2) && (!out_valid || !out_stall);

  // Slot range check and row address.
  assign slot_wide = 32'(client_slot);
  assign slot_ok   = slot_wide < 32'(CLIENTS);

  // Reciprocal product for the bucket index, registered straight away.
  assign prod = (2*TICK_W)'(now_tick) * (2*TICK_W)'(RECIP);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_rq_window <= '0;
      lim_rq_bucket <= '0;
      lim_cn_window <= '0;
      lim_cn_open   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REQ_RATE:  lim_rq_window <= cfg_data;
        REG_REQ_BURST: lim_rq_bucket <= cfg_data;
        REG_CONN_RATE: lim_cn_window <= cfg_data;
        REG_CONN_MAX:  lim_cn_open   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Client row store: open count on top, then one field per bucket.
  cswrl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CLIENTS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_acc),
    .raddr(slot_wide[ADDR_W-1:0]),
    .rdata(rd_row)
  );

  // Write port: zero rows during the clearing pass, the updated row otherwise.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_UPD) && live_q;
      ram_waddr = addr_q;
      ram_wdata = row_new;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == ADDR_W'(CLIENTS - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_acc) state_next = S_MOD;
      S_MOD:   state_next = S_UPD;
      S_UPD:   state_next = S_SUM1;
      S_SUM1:  state_next = S_SUM2;
      S_SUM2:  if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Capture of the event at its transfer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q  <= command;
      tick_q <= now_tick;
      addr_q <= slot_wide[ADDR_W-1:0];
      live_q <= slot_ok && (command == CMD_OPEN || command == CMD_CLOSE ||
                            command == CMD_REQUEST);
      quot_q <= prod[2*TICK_W-1 -: TICK_W];
    end
  end

  // Bucket index: remainder from the approximate quotient, then one correction.
  always_comb begin
    rem = tick_q - TICK_W'(quot_q * TICK_W'(BUCKETS));
    if (rem >= TICK_W'(BUCKETS)) begin
      rem = rem - TICK_W'(BUCKETS);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MOD) begin
      bidx_q <= rem[BIDX_W-1:0];
    end
  end

  // Row update, early verdicts and the window selection of each bucket.
  always_comb begin
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   nc;
    logic [CNT_W-1:0]   rq;
    logic [CNT_W-1:0]   cur_rq;
    logic [CNT_W-1:0]   open_cur;
    logic [CNT_W-1:0]   open_new;
    logic               is_open;
    logic               is_req;
    logic               is_close;
    logic               win;

    is_open      = live_q && (cmd_q == CMD_OPEN);
    is_req       = live_q && (cmd_q == CMD_REQUEST);
    is_close     = live_q && (cmd_q == CMD_CLOSE);
    row_new      = rd_row;
    open_cur     = rd_row[ROW_W-1 -: CNT_W];
    open_new     = open_cur;
    cur_rq       = '0;
    stamp        = '0;
    nc           = '0;
    rq           = '0;
    win          = 1'b0;
    verdict_new  = V_PASS;
    need_sum_new = 1'b0;
    limit_new    = '0;

    for (int b = 0; b < BUCKETS; b++) begin
      stamp = rd_row[b*BKT_W + 2*CNT_W +: STAMP_W];
      nc    = rd_row[b*BKT_W + CNT_W +: CNT_W];
      rq    = rd_row[b*BKT_W +: CNT_W];
      if ((BIDX_W'(b) == bidx_q) && (is_open || is_req)) begin
        // A bucket stamped with another tick starts again at zero.
        if (stamp != tick_q) begin
          stamp = tick_q;
          nc    = '0;
          rq    = '0;
        end
        if (is_open) nc = sat_inc(nc);
        if (is_req)  rq = sat_inc(rq);
        cur_rq = rq;
        row_new[b*BKT_W + 2*CNT_W +: STAMP_W] = stamp;
        row_new[b*BKT_W + CNT_W +: CNT_W]     = nc;
        row_new[b*BKT_W +: CNT_W]             = rq;
      end
      // The window test keeps the carry of the stamp sum.
      win        = ({1'b0, stamp} + (STAMP_W+1)'(BUCKETS)) >= {1'b0, tick_q};
      sel_new[b] = win ? (is_open ? nc : rq) : '0;
    end

    if (is_close) begin
      if (open_cur == '0) begin
        verdict_new = V_NO_CONN;
      end else begin
        open_new = open_cur - 1'b1;
      end
    end

    if (is_open) begin
      open_new = sat_inc(open_cur);
      priority if (lim_cn_open != '0 && open_new > lim_cn_open) begin
        verdict_new = V_BLOCK;
      end else if (lim_rq_bucket != '0 && cur_rq > lim_rq_bucket) begin
        verdict_new = V_BLOCK;
      end else begin
        need_sum_new = (lim_cn_window != '0);
        limit_new    = lim_cn_window;
      end
    end

    if (is_req) begin
      priority if (lim_rq_bucket != '0 && cur_rq > lim_rq_bucket) begin
        verdict_new = V_BLOCK;
      end else begin
        need_sum_new = (lim_rq_window != '0);
        limit_new    = lim_rq_window;
      end
    end

    row_new[ROW_W-1 -: CNT_W] = open_new;
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      verdict_q  <= verdict_new;
      need_sum_q <= need_sum_new;
      limit_q    <= limit_new;
      for (int b = 0; b < BUCKETS; b++) begin
        sel_q[b] <= sel_new[b];
      end
    end
  end

  // First adder level: groups of four buckets.
  always_ff @(posedge clk) begin
    if (state == S_SUM1) begin
      for (int g = 0; g < GROUPS; g++) begin
        logic [PART_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          if (g*4 + k < BUCKETS) begin
            acc = acc + PART_W'(sel_q[g*4 + k]);
          end
        end
        part_q[g] <= acc;
      end
    end
  end

  // Second adder level; the window limit is applied at the result register.
  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + SUM_W'(part_q[g]);
    end
  end

  // Result register; it frees as soon as its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict <= (need_sum_q && total > SUM_W'(limit_q)) ? V_BLOCK : verdict_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cswrl_checker.sv =====
// Port-level checker of the rate limiter core and its bind to the core.
// Depends on cswrl_pkg and client_sliding_window_rate_limiter_core.
`default_nettype none

module cswrl_port_props
  import cswrl_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [VERDICT_W-1:0] verdict
);

  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] pending;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Events taken but whose result transfer has not yet happened.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // A stalled result holds its verdict.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict))
    else $error("stalled result changed");

  // Events are handled one at a time: the event side stalls after a transfer.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("event taken while another is in progress");

  // A fresh result appears only after a matching event transfer.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_xfer, 5))
    else $error("result without a matching event");

  // At most one result waits while one more event is in progress.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many events outstanding");

endmodule

bind client_sliding_window_rate_limiter_core cswrl_port_props u_cswrl_port_props (.*);

`default_nettype wire

// ===== tb/sv/cswrl_checker.sv =====
// Checker of the client sliding-window rate limiter: keeps its own copy of
// the client rows and limits, predicts each verdict and compares the results.
// Depends on cswrl_pkg; instantiated beside the core by the testbench top.
`default_nettype none

module cswrl_checker
  import cswrl_pkg::*;
#(
  parameter int CLIENTS = CLIENTS_DEF,
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [SLOT_W-1:0]     client_slot,
  input  wire logic [TICK_W-1:0]     now_tick,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [VERDICT_W-1:0]  verdict,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned                verdicts_due,
  output int unsigned                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = CLIENTS * BUCKETS;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  // Only the first mismatches are printed; all of them are counted.
  localparam int unsigned PRINT_CAP = 50;

  // Shadow copy of the limits and of the client table.
  logic [CFG_DATA_W-1:0] lim_rq_window, lim_rq_bucket, lim_cn_window, lim_cn_open;
  logic [STAMP_W-1:0]    stamp_mem [ROWS];
  logic [CNT_W-1:0]      conn_mem  [ROWS];
  logic [CNT_W-1:0]      req_mem   [ROWS];
  logic [CNT_W-1:0]      open_mem  [CLIENTS];

  // Verdicts predicted for accepted events, oldest first.
  logic [VERDICT_W-1:0]  verdict_fifo [$];
  logic [VERDICT_W-1:0]  wanted;
  int unsigned           result_no;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("%0t ns checker: %s", $realtime, what);
    end
  endtask

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

  // Sum of one counter over the buckets of a row whose stamp, widened so
  // that adding the ring length cannot wrap, reaches the current tick.
  function automatic logic [31:0] window_total(input bit use_req, input int base,
                                               input logic [TICK_W-1:0] tick);
    logic [31:0]        sum;
    logic [STAMP_W:0]   reach;
    sum = '0;
    for (int b = 0; b < BUCKETS; b++) begin
      reach = {1'b0, stamp_mem[base+b]} + (STAMP_W+1)'(BUCKETS);
      if (reach >= {1'b0, tick}) begin
        sum += 32'(use_req ? req_mem[base+b] : conn_mem[base+b]);
      end
    end
    return sum;
  endfunction

  // Applies one event to the shadow table and returns its verdict.
  function automatic logic [VERDICT_W-1:0] rate_verdict(input logic [CMD_W-1:0]  cmd,
                                                        input logic [SLOT_W-1:0] slot,
                                                        input logic [TICK_W-1:0] tick);
    int                   base;
    int                   row;
    logic [VERDICT_W-1:0] v;
    v = V_PASS;
    if (slot >= CLIENTS) begin
      return V_PASS;
    end
    base = slot * BUCKETS;
    row  = base + (tick % BUCKETS);
    case (cmd)
      CMD_CLOSE: begin
        if (open_mem[slot] == '0) begin
          v = V_NO_CONN;
        end else begin
          open_mem[slot] = open_mem[slot] - 1'b1;
        end
      end
      CMD_OPEN, CMD_REQUEST: begin
        // A stale bucket is restarted for the current tick.
        if (stamp_mem[row] != tick) begin
          stamp_mem[row] = tick;
          conn_mem[row]  = '0;
          req_mem[row]   = '0;
        end
        if (cmd == CMD_OPEN) begin
          conn_mem[row]  = bump(conn_mem[row]);
          open_mem[slot] = bump(open_mem[slot]);
          if (lim_cn_open != '0 && open_mem[slot] > lim_cn_open) begin
            v = V_BLOCK;
          end else if (lim_rq_bucket != '0 && req_mem[row] > lim_rq_bucket) begin
            v = V_BLOCK;
          end else if (lim_cn_window != '0 && window_total(1'b0, base, tick) > lim_cn_window) begin
            v = V_BLOCK;
          end
        end else begin
          req_mem[row] = bump(req_mem[row]);
          if (lim_rq_bucket != '0 && req_mem[row] > lim_rq_bucket) begin
            v = V_BLOCK;
          end else if (lim_rq_window != '0 && window_total(1'b1, base, tick) > lim_rq_window) begin
            v = V_BLOCK;
          end
        end
      end
      default: begin
        // The unused command leaves everything as it is.
      end
    endcase
    return v;
  endfunction

  // Results are compared before the event of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      lim_rq_window = '0;
      lim_rq_bucket = '0;
      lim_cn_window = '0;
      lim_cn_open   = '0;
      for (int i = 0; i < ROWS; i++) begin
        stamp_mem[i] = '0;
        conn_mem[i]  = '0;
        req_mem[i]   = '0;
      end
      for (int i = 0; i < CLIENTS; i++) begin
        open_mem[i] = '0;
      end
      verdict_fifo.delete();
      result_no  = 0;
      fail_count = 0;
    end else begin
      // Result transfer.
      if (out_valid && !out_stall) begin
        if (verdict_fifo.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no event outstanding (result %0d)",
                                    verdict, result_no));
        end else begin
          wanted = verdict_fifo.pop_front();
          if (verdict !== wanted) begin
            report_mismatch($sformatf("verdict %0d, predicted %0d (result %0d)",
                                      verdict, wanted, result_no));
          end
        end
        result_no++;
      end
      // Event transfer.
      if (in_valid && !in_stall) begin
        verdict_fifo.push_back(rate_verdict(command, client_slot, now_tick));
      end
      // Register write transfer; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REQ_RATE:  lim_rq_window = cfg_data;
          REG_REQ_BURST: lim_rq_bucket = cfg_data;
          REG_CONN_RATE: lim_cn_window = cfg_data;
          REG_CONN_MAX:  lim_cn_open   = cfg_data;
          default: begin
          end
        endcase
      end
    end
    verdicts_due = verdict_fifo.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_client_sliding_window_rate_limiter_core.sv =====
// Testbench top of the client sliding-window rate limiter core: clock, reset,
// event and register stimulus, receiver stalls, watchdog and the verdict.
// Depends on cswrl_pkg, the core and cswrl_checker.
`default_nettype none

module tb_client_sliding_window_rate_limiter_core
  import cswrl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT    = 5000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASES         = 8;
  localparam int PHASE_EVENTS   = 153;
  localparam int HOLD_OFF       = 300;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command     = CMD_OPEN;
  logic [SLOT_W-1:0]     client_slot = '0;
  logic [TICK_W-1:0]     now_tick    = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [VERDICT_W-1:0]  verdict;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int unsigned verdicts_due;
  int unsigned fail_count;

  // Idling controls shared by the sender and the receiver.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int quiet_cycles  = 0;

  logic [TICK_W-1:0] cur_tick;
  logic [SLOT_W-1:0] focus [4];

  client_sliding_window_rate_limiter_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .client_slot (client_slot),
    .now_tick    (now_tick),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .verdict     (verdict),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  cswrl_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .client_slot  (client_slot),
    .now_tick     (now_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .verdicts_due (verdicts_due),
    .fail_count   (fail_count)
  );

  always #5 clk = ~clk;

  // Receiver: a requested hold-off is counted down here, otherwise the
  // stall is drawn afresh every cycle.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one event, after a random gap, and returns at the falling edge
  // after its transfer with valid still high.
  task automatic offer_event(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [TICK_W-1:0] tick);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    client_slot <= slot;
    now_tick    <= tick;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // One register write; valid stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Waits at the falling edge until every predicted verdict has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_due != 0) @(negedge clk);
  endtask

  // Writes all four limits and one index the block does not decode.
  task automatic set_limits(input logic [CFG_DATA_W-1:0] rq_window, rq_bucket, cn_window,
                            cn_open);
    drain();
    write_reg(REG_REQ_RATE, rq_window);
    write_reg(REG_REQ_BURST, rq_bucket);
    write_reg(REG_CONN_RATE, cn_window);
    write_reg(REG_CONN_MAX, cn_open);
    write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 35) return CFG_DATA_W'(1);
    return CFG_DATA_W'($urandom_range(2, 24));
  endfunction

  // Random traffic concentrated on a few clients with a slowly moving tick,
  // mixed with stray clients, jumps of the tick and late events.
  task automatic random_events(input int count);
    int                r;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) cmd = CMD_REQUEST;
      else if (r < 72) cmd = CMD_OPEN;
      else if (r < 94) cmd = CMD_CLOSE;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 85) slot = focus[$urandom_range(0, 3)];
      else slot = SLOT_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 22) cur_tick = cur_tick + $urandom_range(1, 3);
      else if (r < 27) cur_tick = cur_tick + $urandom_range(4, 12);
      else if (r < 30) cur_tick = $urandom;
      if ($urandom_range(0, 99) < 5) offer_event(cmd, slot, cur_tick - $urandom_range(1, 3));
      else offer_event(cmd, slot, cur_tick);
    end
  endtask

  // Main sequence: reset, directed cases, random phases, verdict.
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Unlimited: close with nothing open, basic traffic, field extremes.
    offer_event(CMD_CLOSE, 8'd0, 32'd0);
    offer_event(CMD_OPEN, 8'd0, 32'd0);
    offer_event(CMD_REQUEST, 8'd0, 32'd0);
    offer_event(CMD_CLOSE, 8'd0, 32'd0);
    offer_event(CMD_UNUSED, 8'd255, 32'hFFFF_FFFF);
    offer_event(CMD_REQUEST, 8'd255, 32'hFFFF_FFFF);
    offer_event(CMD_OPEN, 8'd255, 32'hFFFF_FFFF);
    offer_event(CMD_CLOSE, 8'd255, 32'hFFFF_FFFF);

    // Small limits: burst, window, concurrency and burst seen by an open.
    set_limits(16'd3, 16'd2, 16'd2, 16'd1);
    repeat (3) offer_event(CMD_REQUEST, 8'd1, 32'd100);
    offer_event(CMD_OPEN, 8'd1, 32'd100);
    offer_event(CMD_REQUEST, 8'd1, 32'd101);
    offer_event(CMD_OPEN, 8'd2, 32'd5);
    offer_event(CMD_OPEN, 8'd2, 32'd5);
    repeat (3) offer_event(CMD_CLOSE, 8'd2, 32'd5);
    // Stamps near the top of the tick range stay in the window after wrap.
    offer_event(CMD_REQUEST, 8'd4, 32'hFFFF_FFFE);
    offer_event(CMD_REQUEST, 8'd4, 32'hFFFF_FFFF);
    offer_event(CMD_REQUEST, 8'd4, 32'd1);
    offer_event(CMD_REQUEST, 8'd4, 32'd2);
    // A later stamp counts; stamps more than a ring behind do not.
    offer_event(CMD_REQUEST, 8'd5, 32'd1001);
    offer_event(CMD_REQUEST, 8'd5, 32'd995);
    offer_event(CMD_REQUEST, 8'd5, 32'd1010);

    // Random phases under each idling mode and several limit settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_limits('0, '0, '0, '0);
        1: set_limits('1, '1, '1, '1);
        2: set_limits(16'd1, 16'd1, 16'd1, 16'd1);
        default: set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (int f = 0; f < 4; f++) focus[f] = SLOT_W'($urandom_range(0, 255));
      cur_tick = ($urandom_range(0, 1) != 0) ? $urandom : TICK_W'($urandom_range(0, 40));
      // Long hold-off of the receiver while events keep coming.
      if (p == 4) hold_cycles = HOLD_OFF;
      random_events(PHASE_EVENTS);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && verdicts_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
